@@ rtl/core/msce_pkg.sv @@
// Package for the multi-standard CRC engine: mode codes, queue item type,
// and the per-mode CRC constants and byte-fold function.
// No dependencies.
package msce_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned CrcW   = 64;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register index of the mode register on the APB port.
  localparam logic RegAlgorithmMode = 1'b0;

  // Algorithm codes as written to the mode register.
  typedef enum logic [ModeW-1:0] {
    MODE_CRC8        = 3'd0,
    MODE_CRC16_CCITT = 3'd1,
    MODE_CRC16_ARC   = 3'd2,
    MODE_CRC32       = 3'd3,
    MODE_CRC32P4     = 3'd4,
    MODE_CRC64       = 3'd5
  } mode_e;

  localparam logic [ModeW-1:0] ModeReset = MODE_CRC32;

  // One classified byte, handed from front to back through the queue.
  typedef struct packed {
    mode_e             mode;
    logic              load;
    logic [CrcW-1:0]   load_val;
    logic [DataW-1:0]  data_byte;
    logic              ends_call;
  } item_t;

  // Unused codes behave as CRC-64.
  function automatic mode_e clamp_mode(logic [ModeW-1:0] raw);
    mode_e m;
    case (raw)
      MODE_CRC8:        m = MODE_CRC8;
      MODE_CRC16_CCITT: m = MODE_CRC16_CCITT;
      MODE_CRC16_ARC:   m = MODE_CRC16_ARC;
      MODE_CRC32:       m = MODE_CRC32;
      MODE_CRC32P4:     m = MODE_CRC32P4;
      default:          m = MODE_CRC64;
    endcase
    return m;
  endfunction

  function automatic logic [CrcW-1:0] width_mask(mode_e m);
    logic [CrcW-1:0] r;
    unique case (m)
      MODE_CRC8:                         r = 64'h0000_0000_0000_00FF;
      MODE_CRC16_CCITT, MODE_CRC16_ARC:  r = 64'h0000_0000_0000_FFFF;
      MODE_CRC32, MODE_CRC32P4:          r = 64'h0000_0000_FFFF_FFFF;
      default:                           r = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return r;
  endfunction

  function automatic logic [CrcW-1:0] init_value(mode_e m);
    return (m == MODE_CRC16_ARC) ? '0 : width_mask(m);
  endfunction

  function automatic logic [CrcW-1:0] xorout_value(mode_e m);
    return (m == MODE_CRC16_CCITT || m == MODE_CRC16_ARC) ? '0 : width_mask(m);
  endfunction

  function automatic logic [CrcW-1:0] reflected_poly(mode_e m);
    logic [CrcW-1:0] p;
    unique case (m)
      MODE_CRC16_ARC: p = 64'h0000_0000_0000_A001;
      MODE_CRC32:     p = 64'h0000_0000_EDB8_8320;
      MODE_CRC32P4:   p = 64'h0000_0000_C8DF_352F;
      default:        p = 64'hC96C_5795_D787_0F42;
    endcase
    return p;
  endfunction

  // Fold one byte into a register already cut to the mode's width.
  // Eight unrolled shift/XOR steps form a plain XOR tree.
  function automatic logic [CrcW-1:0] fold_byte(mode_e m, logic [CrcW-1:0] crc,
                                               logic [DataW-1:0] b);
    logic [7:0]      r8;
    logic [15:0]     r16;
    logic [CrcW-1:0] r;
    logic [CrcW-1:0] poly;
    r8   = crc[7:0] ^ b;
    r16  = crc[15:0] ^ {b, 8'h00};
    r    = crc ^ {{(CrcW-DataW){1'b0}}, b};
    poly = reflected_poly(m);
    for (int i = 0; i < 8; i++) begin
      r8  = r8[7]   ? ((r8 << 1) ^ 8'h1D)      : (r8 << 1);
      r16 = r16[15] ? ((r16 << 1) ^ 16'h1021)  : (r16 << 1);
      r   = r[0]    ? ((r >> 1) ^ poly)        : (r >> 1);
    end
    unique case (m)
      MODE_CRC8:        r = {{(CrcW-8){1'b0}}, r8};
      MODE_CRC16_CCITT: r = {{(CrcW-16){1'b0}}, r16};
      default:          r = r & width_mask(m);
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/msce_in_if.sv @@
// Input channel of the CRC engine: valid/ready plus one message byte
// and its call flags. Depends on msce_pkg.
interface msce_in_if;
  logic                       valid;
  logic                       ready;
  logic [msce_pkg::DataW-1:0] data_byte;
  logic                       starts_call;
  logic                       ends_call;
  logic                       first_call;
  logic [msce_pkg::CrcW-1:0]  start_value;

  modport source (output valid, data_byte, starts_call, ends_call, first_call,
                  start_value, input ready);
  modport sink   (input valid, data_byte, starts_call, ends_call, first_call,
                  start_value, output ready);
endinterface

@@ rtl/core/msce_out_if.sv @@
// Output channel of the CRC engine: valid/ready plus the finalized CRC
// and end-of-call flag. Depends on msce_pkg.
interface msce_out_if;
  logic                      valid;
  logic                      ready;
  logic [msce_pkg::CrcW-1:0] crc_result;
  logic                      call_done;

  modport source (output valid, crc_result, call_done, input ready);
  modport sink   (input valid, crc_result, call_done, output ready);
endinterface

@@ rtl/core/multi_standard_crc_engine_top.sv @@
// Top level of the multi-standard CRC engine: APB mode register, front end,
// item queue and back end. Depends on msce_pkg, msce_in_if, msce_out_if.
//
// The engine takes one message byte per transaction and returns one finalized
// CRC per byte (CRC-8 SAE J1850, CRC-16 CCITT-FALSE, CRC-16 ARC, CRC-32,
// CRC-32P4, CRC-64 ECMA, chosen by the mode register at byte address 0; codes
// 6 and 7 run CRC-64). It sustains one byte per clock cycle while the output
// is ready; the back end folds a whole byte into the CRC register at once.
// A result passes through the two-entry queue and then the output register.
// Input and output stall independently; the queue and the output register
// keep both sides moving.
// Change the mode only while no transaction is in flight.
module multi_standard_crc_engine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msce_pkg::ApbAddrW-1:0] paddr,
  input  logic [msce_pkg::ApbDataW-1:0] pwdata,
  output logic [msce_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  msce_in_if.sink                       in_i,
  msce_out_if.source                    out_o
);

  logic [msce_pkg::ModeW-1:0] mode;
  logic                       q_ready;
  logic                       q_push;
  logic                       q_valid;
  logic                       q_pop;
  msce_pkg::item_t            q_item_in;
  msce_pkg::item_t            q_item_out;

  msce_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  msce_front u_front (
    .in_i      (in_i),
    .mode_i    (mode),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_item_o  (q_item_in)
  );

  msce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item_out)
  );

  msce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item_out),
    .item_pop_o   (q_pop),
    .out_o        (out_o)
  );

endmodule

@@ rtl/core/msce_cfg.sv @@
// APB-style configuration register block holding the algorithm mode.
// Depends on msce_pkg.
module msce_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msce_pkg::ApbAddrW-1:0] paddr,
  input  logic [msce_pkg::ApbDataW-1:0] pwdata,
  output logic [msce_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output logic [msce_pkg::ModeW-1:0]    mode_o
);

  logic [msce_pkg::ModeW-1:0] mode_q, mode_d;
  logic                       wr_en;
  logic                       reg_idx;

  // Word index: one register per 4-byte word
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == msce_pkg::RegAlgorithmMode);
  assign pready  = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[msce_pkg::ModeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= msce_pkg::ModeReset;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == msce_pkg::RegAlgorithmMode) begin
      prdata = {{(msce_pkg::ApbDataW-msce_pkg::ModeW){1'b0}}, mode_q};
    end
  end

  assign mode_o = mode_q;

endmodule

@@ rtl/core/msce_front.sv @@
// Front end: accepts input bytes, resolves the mode and the register
// load value, and pushes a classified item into the queue. Depends on msce_pkg.
module msce_front (
  msce_in_if.sink                     in_i,
  input  logic [msce_pkg::ModeW-1:0]  mode_i,
  input  logic                        q_ready_i,
  output logic                        q_push_o,
  output msce_pkg::item_t             q_item_o
);

  msce_pkg::mode_e           mode;
  logic [msce_pkg::CrcW-1:0] mask;
  logic [msce_pkg::CrcW-1:0] start_val;

  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid && q_ready_i;

  // Classify: clamp mode, build the value loaded at a call start
  always_comb begin
    mode = msce_pkg::clamp_mode(mode_i);
    mask = msce_pkg::width_mask(mode);
    if (msce_pkg::xorout_value(mode) != '0) begin
      start_val = ~in_i.start_value & mask;
    end else begin
      start_val = in_i.start_value & mask;
    end
    q_item_o.mode      = mode;
    q_item_o.load      = in_i.starts_call;
    q_item_o.load_val  = in_i.first_call ? msce_pkg::init_value(mode) : start_val;
    q_item_o.data_byte = in_i.data_byte;
    q_item_o.ends_call = in_i.ends_call;
  end

endmodule

@@ rtl/core/msce_queue.sv @@
// Two-entry queue between front and back end.
// Depends on msce_pkg.
module msce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  msce_pkg::item_t item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output msce_pkg::item_t item_o
);

  msce_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/core/msce_back.sv @@
// Back end: folds one queued byte per unstalled cycle into the CRC register
// and holds the finalized result in an output register. Depends on msce_pkg.
module msce_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  msce_pkg::item_t item_i,
  output logic            item_pop_o,
  msce_out_if.source      out_o
);

  logic [msce_pkg::CrcW-1:0] crc_q, crc_d;
  logic [msce_pkg::CrcW-1:0] res_q, res_d;
  logic                      done_q, done_d;
  logic                      out_valid_q, out_valid_d;
  logic [msce_pkg::CrcW-1:0] mask;
  logic [msce_pkg::CrcW-1:0] crc_in;
  logic [msce_pkg::CrcW-1:0] crc_new;

  // Take an item when the output slot is free or being drained
  assign item_pop_o = item_valid_i && (!out_valid_q || out_o.ready);

  // Byte fold
  always_comb begin
    mask    = msce_pkg::width_mask(item_i.mode);
    crc_in  = item_i.load ? item_i.load_val : (crc_q & mask);
    crc_new = msce_pkg::fold_byte(item_i.mode, crc_in, item_i.data_byte);
  end

  // Next state of CRC register and output slot
  always_comb begin
    crc_d       = crc_q;
    res_d       = res_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (item_pop_o) begin
      crc_d       = crc_new;
      res_d       = (crc_new ^ msce_pkg::xorout_value(item_i.mode)) & mask;
      done_d      = item_i.ends_call;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    done_q <= done_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.crc_result = res_q;
  assign out_o.call_done  = done_q;

endmodule

@@ bench/msce_crc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the multi-standard CRC engine: watches the APB port and both
// streams, predicts each finalized CRC and compares it with the result.
// Depends on msce_pkg, msce_in_if and msce_out_if.
module msce_crc_checker
  import msce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  msce_in_if                  in_mon,
  msce_out_if                 out_mon,
  output int unsigned         pending_o,
  output int unsigned         mismatch_o
);

  localparam logic [ApbAddrW-1:0] ModeRegAddr = ApbAddrW'(4 * RegAlgorithmMode);

  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic            done;
  } crc_expect_t;

  crc_expect_t      expected_crcs[$];
  logic [ModeW-1:0] mode_raw = ModeReset;
  logic [CrcW-1:0]  crc_state = '1;
  int unsigned      bytes_taken = 0;
  int unsigned      results_seen = 0;
  int unsigned      mismatch_cnt = 0;

  assign pending_o  = bytes_taken - results_seen;
  assign mismatch_o = mismatch_cnt;

  // codes 6 and 7 run as CRC-64
  function automatic mode_e effective_mode(logic [ModeW-1:0] raw);
    return (raw > MODE_CRC64) ? MODE_CRC64 : mode_e'(raw);
  endfunction

  function automatic logic [CrcW-1:0] crc_mask(mode_e m);
    case (m)
      MODE_CRC8:                        return 64'hFF;
      MODE_CRC16_CCITT, MODE_CRC16_ARC: return 64'hFFFF;
      MODE_CRC32, MODE_CRC32P4:         return 64'hFFFF_FFFF;
      default:                          return '1;
    endcase
  endfunction

  function automatic logic [CrcW-1:0] crc_xorout(mode_e m);
    return (m == MODE_CRC16_CCITT || m == MODE_CRC16_ARC) ? '0 : crc_mask(m);
  endfunction

  // bitwise byte fold, msb-first for CRC-8 and CCITT, lsb-first otherwise
  function automatic logic [CrcW-1:0] fold_crc(mode_e m, logic [CrcW-1:0] r,
                                               logic [DataW-1:0] b);
    logic [CrcW-1:0] poly;
    case (m)
      MODE_CRC16_ARC: poly = 64'hA001;
      MODE_CRC32:     poly = 64'hEDB8_8320;
      MODE_CRC32P4:   poly = 64'hC8DF_352F;
      default:        poly = 64'hC96C_5795_D787_0F42;
    endcase
    if (m == MODE_CRC8) begin
      r = {56'd0, r[7:0] ^ b};
      for (int k = 0; k < 8; k++) r = r[7] ? ((r << 1) ^ 64'h1D) : (r << 1);
    end else if (m == MODE_CRC16_CCITT) begin
      r = {48'd0, r[15:0] ^ {b, 8'h00}};
      for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ 64'h1021) : (r << 1);
    end else begin
      r = r ^ {56'd0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r & crc_mask(m);
  endfunction

  task automatic note_mismatch(string what, logic [CrcW-1:0] exp_v, logic [CrcW-1:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  // results are compared before the new byte is queued
  always @(posedge clk_i or negedge rst_ni) begin
    mode_e           m;
    logic [CrcW-1:0] mask;
    logic [CrcW-1:0] r;
    crc_expect_t     exp_item;
    if (!rst_ni) begin
      mode_raw     = ModeReset;
      crc_state    = '1;
      expected_crcs.delete();
      bytes_taken  <= 0;
      results_seen <= 0;
    end else begin
      // mode register write
      if (psel && penable && pwrite && pready && paddr == ModeRegAddr)
        mode_raw = pwdata[ModeW-1:0];

      // result transaction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_crcs.size() == 0) begin
          note_mismatch("unexpected result", '0, out_mon.crc_result);
        end else begin
          exp_item = expected_crcs.pop_front();
          results_seen <= results_seen + 1;
          if (out_mon.crc_result !== exp_item.crc)
            note_mismatch("crc_result", exp_item.crc, out_mon.crc_result);
          if (out_mon.call_done !== exp_item.done)
            note_mismatch("call_done", {63'd0, exp_item.done}, {63'd0, out_mon.call_done});
        end
      end

      // byte transaction: load, fold, finalize
      if (in_mon.valid && in_mon.ready) begin
        m    = effective_mode(mode_raw);
        mask = crc_mask(m);
        r    = crc_state & mask;
        if (in_mon.starts_call) begin
          if (in_mon.first_call)
            r = (m == MODE_CRC16_ARC) ? '0 : mask;
          else if (crc_xorout(m) != '0)
            r = ~in_mon.start_value & mask;
          else
            r = in_mon.start_value & mask;
        end
        r = fold_crc(m, r, in_mon.data_byte);
        crc_state = r;
        exp_item.crc  = (r ^ crc_xorout(m)) & mask;
        exp_item.done = in_mon.ends_call;
        expected_crcs.push_back(exp_item);
        bytes_taken <= bytes_taken + 1;
      end
    end
  end

endmodule

@@ bench/multi_standard_crc_engine_top_test.sv @@
`timescale 1ns / 1ps
// Top of the CRC engine testbench: clock, reset, APB mode writes and byte
// stimulus with random stalls. Depends on msce_pkg, msce_in_if, msce_out_if,
// msce_crc_checker and multi_standard_crc_engine_top.
module multi_standard_crc_engine_top_test;
  import msce_pkg::*;

  localparam logic [ApbAddrW-1:0] ModeRegAddr = ApbAddrW'(4 * RegAlgorithmMode);
  localparam logic [ModeW-1:0]    ModeUnused6 = 3'd6;
  localparam logic [ModeW-1:0]    ModeUnused7 = 3'd7;
  localparam int unsigned         RandomBytes = 1950;
  localparam int unsigned         CycleLimit  = 200_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned      results_pending;
  int unsigned      mismatch_total;
  int unsigned      cycle_cnt = 0;
  bit               idle_on = 1'b1;
  logic [ModeW-1:0] cur_mode = ModeReset;
  int unsigned      bytes_sent = 0;
  int unsigned      calls_started = 0;
  int unsigned      mode_bytes[8];

  msce_in_if  in_ch ();
  msce_out_if out_ch ();

  multi_standard_crc_engine_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  msce_crc_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .pending_o  (results_pending),
    .mismatch_o (mismatch_total)
  );

  always #4 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               results_pending);
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ch.ready <= !idle_on || ($urandom_range(99) >= 25);
  end

  // one byte transaction, with random idle cycles ahead of it
  task automatic send_byte(logic [DataW-1:0] b, bit st, bit en, bit fc, logic [CrcW-1:0] sv);
    while (idle_on && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.starts_call <= st;
    in_ch.ends_call   <= en;
    in_ch.first_call  <= fc;
    in_ch.start_value <= sv;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    mode_bytes[cur_mode]++;
    if (st) calls_started++;
  endtask

  // stop sending until every queued result has come back
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  // mode write between transactions; upper data bits are don't-care
  task automatic set_mode(logic [ModeW-1:0] m);
    logic [ApbDataW-1:0] w;
    wait_results();
    w          = $urandom;
    w[ModeW-1:0] = m;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ModeRegAddr;
    pwdata  <= w;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    mode_e            all_modes[6];
    int unsigned      rand_bytes;
    int unsigned      len;
    bit               noise;
    bit               st;
    bit               en;
    logic [DataW-1:0] b;
    logic [CrcW-1:0]  sv;

    all_modes = '{MODE_CRC8, MODE_CRC16_CCITT, MODE_CRC16_ARC, MODE_CRC32,
                  MODE_CRC32P4, MODE_CRC64};
    rand_bytes = 0;
    foreach (mode_bytes[i]) mode_bytes[i] = 0;

    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.starts_call = 1'b0;
    in_ch.ends_call   = 1'b0;
    in_ch.first_call  = 1'b0;
    in_ch.start_value = '0;
    out_ch.ready      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset mode, no load: continues from the all-ones register; end without start
    send_byte(8'h00, 1'b0, 1'b1, 1'b0, '0);

    // two-byte call from the initial value in every mode
    foreach (all_modes[i]) begin
      set_mode(all_modes[i]);
      send_byte(8'hFF, 1'b1, 1'b0, 1'b1, '1);
      send_byte(8'h00, 1'b0, 1'b1, 1'b0, '0);
    end

    // unused codes fall back to CRC-64
    set_mode(ModeUnused6);
    send_byte(8'h5A, 1'b1, 1'b1, 1'b0, '1);
    set_mode(ModeUnused7);
    send_byte(8'hA5, 1'b1, 1'b1, 1'b0, '0);

    // chained start values with and without the final XOR
    set_mode(MODE_CRC16_CCITT);
    send_byte(8'h31, 1'b1, 1'b1, 1'b0, '1);
    set_mode(MODE_CRC8);
    send_byte(8'h80, 1'b1, 1'b1, 1'b0, '0);

    // mode change within a call, narrowing and then widening
    set_mode(MODE_CRC64);
    send_byte(8'hC3, 1'b1, 1'b0, 1'b1, '0);
    set_mode(MODE_CRC8);
    send_byte(8'h3C, 1'b0, 1'b1, 1'b0, '0);
    set_mode(MODE_CRC16_ARC);
    send_byte(8'h01, 1'b1, 1'b0, 1'b0, 64'h0123_4567_89AB_CDEF);
    set_mode(MODE_CRC32P4);
    send_byte(8'hFE, 1'b0, 1'b1, 1'b1, '1);

    // random calls; a few per mode setting, some with broken framing
    while (rand_bytes < RandomBytes) begin
      if ($urandom_range(7) == 0) set_mode(ModeW'($urandom_range(7)));
      else if ($urandom_range(15) == 0) wait_results();
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        noise = ($urandom_range(9) == 0);
        st = (k == 0) ? !noise : (noise && $urandom_range(1));
        en = (k == len - 1) ? (!noise || $urandom_range(1)) : (noise && $urandom_range(1));
        case ($urandom_range(3))
          0:       sv = '1;
          1:       sv = '0;
          default: sv = {$urandom, $urandom};
        endcase
        case ($urandom_range(7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = DataW'($urandom);
        endcase
        send_byte(b, st, en, $urandom_range(1), sv);
        rand_bytes++;
        // one long stretch with both sides streaming flat out
        idle_on = (rand_bytes < 800 || rand_bytes >= 1100);
      end
    end

    wait_results();
    repeat (10) @(posedge clk_i);

    $display("%0d bytes in %0d started calls, %0d mismatches", bytes_sent,
             calls_started, mismatch_total);
    $display("bytes per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_bytes[0], mode_bytes[1], mode_bytes[2], mode_bytes[3],
             mode_bytes[4], mode_bytes[5], mode_bytes[6], mode_bytes[7]);
    if (mismatch_total == 0 && results_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
